// ----- design/rct_pkg.sv -----
// rct_pkg: shared types and constants for the RNA codon translator.
// Holds the base codes, the standard genetic code table and the result record.
// No dependencies.
`timescale 1ns / 1ps

package rct_pkg;

  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_G = 8'h47;
  localparam logic [7:0] CHAR_U = 8'h55;

  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_U = 2'd3;

  localparam logic [1:0] PHASE_LAST = 2'd2;

  localparam logic       CAUSE_STOP = 1'b0;
  localparam logic       CAUSE_BAD  = 1'b1;

  localparam logic [7:0] STOP_MARK  = 8'h5F;
  localparam logic [7:0] AA_NONE    = 8'h00;

  // first*16 + second*4 + third; entry 0 is the leftmost character
  localparam logic [64*8-1:0] CODE_STR =
    "KNKNTTTTRSRSIIMIQHQHPPPPRRRRLLLLEDEDAAAAGGGGVVVV_Y_YSSSS_CWCLFLF";

  typedef struct packed {
    logic       emit;
    logic [7:0] amino_acid;
    logic       ended;
    logic       end_cause;
  } rct_result_t;

  function automatic logic [7:0] aa_lookup(input logic [5:0] idx);
    logic [8:0] pos;
    pos = {~idx, 3'b000};
    return CODE_STR[pos +: 8];
  endfunction

endpackage

// ----- design/rct_frame.sv -----
// rct_frame: input register, codon framing state and codon translation.
// Produces one result record per consumed request. Depends on rct_pkg.
`timescale 1ns / 1ps

module rct_frame (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         nucleotide,
  input  logic               first,
  input  logic               advance,
  output logic               held_valid,
  output rct_pkg::rct_result_t result
);

  logic       s_valid;
  logic [7:0] s_nuc;
  logic       s_first;

  logic [1:0] phase, phase_next;
  logic [3:0] held_bases, held_next;
  logic       codon_bad, bad_next;
  logic       halted, halted_next;

  logic [1:0] eff_phase;
  logic [3:0] eff_held;
  logic       eff_bad, eff_halt;
  logic [1:0] code;
  logic       base_bad;
  logic       bad_all;
  logic [7:0] aa;
  logic       take;

  assign held_valid = s_valid;
  assign in_stall   = s_valid && !advance;
  assign take       = s_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (!in_stall) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s_nuc   <= nucleotide;
      s_first <= first;
    end
  end

  always_comb begin
    unique case (s_nuc)
      rct_pkg::CHAR_A: begin code = rct_pkg::BASE_A; base_bad = 1'b0; end
      rct_pkg::CHAR_C: begin code = rct_pkg::BASE_C; base_bad = 1'b0; end
      rct_pkg::CHAR_G: begin code = rct_pkg::BASE_G; base_bad = 1'b0; end
      rct_pkg::CHAR_U: begin code = rct_pkg::BASE_U; base_bad = 1'b0; end
      default:         begin code = rct_pkg::BASE_A; base_bad = 1'b1; end
    endcase
  end

  always_comb begin
    eff_phase = s_first ? 2'd0 : phase;
    eff_held  = s_first ? 4'd0 : held_bases;
    eff_bad   = s_first ? 1'b0 : codon_bad;
    eff_halt  = s_first ? 1'b0 : halted;
    bad_all   = eff_bad || base_bad;
    aa        = rct_pkg::aa_lookup({eff_held, code});

    phase_next  = eff_phase;
    held_next   = eff_held;
    bad_next    = eff_bad;
    halted_next = eff_halt;
    result      = '0;

    if (!eff_halt) begin
      if (eff_phase < rct_pkg::PHASE_LAST) begin
        phase_next = eff_phase + 2'd1;
        held_next  = {eff_held[1:0], code};
        bad_next   = bad_all;
      end else begin
        phase_next  = 2'd0;
        held_next   = 4'd0;
        bad_next    = 1'b0;
        result.emit = 1'b1;
        if (bad_all) begin
          result.ended     = 1'b1;
          result.end_cause = rct_pkg::CAUSE_BAD;
          halted_next      = 1'b1;
        end else if (aa == rct_pkg::STOP_MARK) begin
          result.ended     = 1'b1;
          result.end_cause = rct_pkg::CAUSE_STOP;
          halted_next      = 1'b1;
        end else begin
          result.amino_acid = aa;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= 2'd0;
      held_bases <= 4'd0;
      codon_bad  <= 1'b0;
      halted     <= 1'b0;
    end else if (take) begin
      phase      <= phase_next;
      held_bases <= held_next;
      codon_bad  <= bad_next;
      halted     <= halted_next;
    end
  end

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase != 2'd3)
    else $error("framing phase out of range");

  a_halt_clear: assert property (@(posedge clk) disable iff (rst)
    halted |-> (phase == 2'd0 && held_bases == 4'd0 && !codon_bad))
    else $error("frame not cleared while halted");

  a_end_halts: assert property (@(posedge clk) disable iff (rst)
    (take && result.emit && result.ended) |=> halted)
    else $error("ending codon did not halt translation");

endmodule

// ----- design/rct_out.sv -----
// rct_out: result register between the translator and the output channel.
// Depends on rct_pkg.
`timescale 1ns / 1ps

module rct_out (
  input  logic               clk,
  input  logic               rst,
  input  logic               held_valid,
  input  rct_pkg::rct_result_t result,
  output logic               advance,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         amino_acid,
  output logic               ended,
  output logic               end_cause
);

  assign advance = !(out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= held_valid && result.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && held_valid && result.emit) begin
      amino_acid <= result.amino_acid;
      ended      <= result.ended;
      end_cause  <= result.end_cause;
    end
  end

  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ended) |-> (amino_acid == rct_pkg::AA_NONE))
    else $error("ending result carries an amino acid");

  a_cause_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ended) |-> (end_cause == rct_pkg::CAUSE_STOP))
    else $error("end cause set on a normal result");

endmodule

// ----- design/rna_codon_translator.sv -----
// RNA codon translator: takes one ASCII base per unstalled cycle and returns one
// amino acid letter per complete codon; a stop codon or a base other than A, C,
// G, U gives one ending result (ended=1, end_cause 0 for stop, 1 for bad base)
// and then nothing until a request with first=1. Sustained rate is one base per
// cycle while out_stall is low; a base passes the input register and then the
// result register, with the framing and table lookup between them.
`timescale 1ns / 1ps

module rna_codon_translator (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] nucleotide,
  input  logic       first,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] amino_acid,
  output logic       ended,
  output logic       end_cause
);

  logic                 advance;
  logic                 held_valid;
  rct_pkg::rct_result_t result;

  rct_frame u_frame (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .nucleotide (nucleotide),
    .first      (first),
    .advance    (advance),
    .held_valid (held_valid),
    .result     (result)
  );

  rct_out u_out (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .result     (result),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .amino_acid (amino_acid),
    .ended      (ended),
    .end_cause  (end_cause)
  );

endmodule
